@@ hdl/lps_pkg.sv @@
package lps_pkg;

    // Field and port widths fixed by the interface.
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned COUNT_W     = 32;
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned MODE_W      = 2;
    localparam int unsigned PLEN_W      = 4;

    // Default upper bound of the pattern length.
    localparam int unsigned PATTERN_MAX_DEF = 8;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_SEARCH_MODE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

    // Search modes.
    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COUNT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ALL   = 2'd2;

    // Result kinds.
    localparam logic KIND_LINE  = 1'b0;
    localparam logic KIND_TOTAL = 1'b1;

    // Line terminator.
    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;

    // Saturation value of the line, total and occurrence counters.
    localparam logic [COUNT_W-1:0] COUNT_SAT = {COUNT_W{1'b1}};

    // Per-request control from the top level to the datapath.
    typedef struct packed {
        logic              update;   // a data byte is processed
        logic              clear;    // end of file, clear the file state
        logic              newline;  // the byte closes its line
        logic [BYTE_W-1:0] data;
    } t_step;

    // One result item.
    typedef struct packed {
        logic               valid;
        logic               kind;
        logic [COUNT_W-1:0] line_number;
        logic [COUNT_W-1:0] count;
    } t_result;

endpackage

@@ hdl/lps_window.sv @@
module lps_window #(
    parameter int unsigned PATTERN_MAX = lps_pkg::PATTERN_MAX_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lps_pkg::t_step              i_step,
    input  logic [8*PATTERN_MAX-1:0]    i_pattern,
    input  logic [lps_pkg::PLEN_W-1:0]  i_pattern_length,
    output logic                        o_hit
);

    localparam int unsigned WIN_W  = 8 * PATTERN_MAX;
    localparam int unsigned FILL_W = $clog2(PATTERN_MAX + 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(PATTERN_MAX);

    logic [WIN_W-1:0]                 r_window;
    logic [FILL_W-1:0]                r_fill;
    logic [WIN_W+lps_pkg::BYTE_W-1:0] shift_wide;
    logic [WIN_W-1:0]                 shifted;
    logic [FILL_W-1:0]                fill_next;
    logic [lps_pkg::PLEN_W-1:0]       len_eff;
    logic                             all_eq;

    // Shift the new byte into the newest slot and count bytes seen in the line.
    assign shift_wide = {r_window, i_step.data};
    assign shifted    = shift_wide[WIN_W-1:0];
    assign fill_next  = (r_fill == FILL_MAX) ? r_fill : r_fill + FILL_W'(1);

    // Clamp the configured length into 1..PATTERN_MAX.
    always_comb begin
        if (i_pattern_length == '0) begin
            len_eff = lps_pkg::PLEN_W'(1);
        end else if (i_pattern_length > lps_pkg::PLEN_W'(PATTERN_MAX)) begin
            len_eff = lps_pkg::PLEN_W'(PATTERN_MAX);
        end else begin
            len_eff = i_pattern_length;
        end
    end

    // Compare the newest bytes with the pattern for the selected length.
    // The first pattern byte lines up with the oldest of the compared bytes.
    always_comb begin
        o_hit  = 1'b0;
        all_eq = 1'b0;
        for (int l = 1; l <= PATTERN_MAX; l++) begin
            all_eq = 1'b1;
            for (int i = 0; i < PATTERN_MAX; i++) begin
                if (i < l) begin
                    if (i_pattern[8*i +: 8] != shifted[8*(l-1-i) +: 8]) begin
                        all_eq = 1'b0;
                    end
                end
            end
            if (len_eff == lps_pkg::PLEN_W'(l) && fill_next >= FILL_W'(l)) begin
                o_hit = all_eq;
            end
        end
    end

    // Window state: cleared by a newline and at end of file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_fill   <= '0;
        end else if (i_step.clear) begin
            r_window <= '0;
            r_fill   <= '0;
        end else if (i_step.update) begin
            if (i_step.newline) begin
                r_window <= '0;
                r_fill   <= '0;
            end else begin
                r_window <= shifted;
                r_fill   <= fill_next;
            end
        end
    end

endmodule

@@ hdl/lps_tally.sv @@
module lps_tally (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lps_pkg::t_step              i_step,
    input  logic                        i_hit,
    input  logic [lps_pkg::MODE_W-1:0]  i_mode,
    output logic                        o_finished,
    output lps_pkg::t_result            o_result
);

    logic [lps_pkg::COUNT_W-1:0] r_line;
    logic [lps_pkg::COUNT_W-1:0] r_total;
    logic [lps_pkg::COUNT_W-1:0] r_line_occ;
    logic                        r_has_match;
    logic                        r_finished;

    logic                        occ_inc;
    logic [lps_pkg::COUNT_W:0]   sum_wide;
    logic [lps_pkg::COUNT_W-1:0] total_next;
    logic [lps_pkg::COUNT_W-1:0] line_next;
    logic                        has_next;
    logic                        line_mode;

    assign o_finished = r_finished;

    // Saturating counter arithmetic for the closing line.
    always_comb begin
        occ_inc    = i_hit && (r_line_occ != lps_pkg::COUNT_SAT);
        sum_wide   = {1'b0, r_total} + {1'b0, r_line_occ}
                   + (lps_pkg::COUNT_W + 1)'(occ_inc);
        total_next = sum_wide[lps_pkg::COUNT_W] ? lps_pkg::COUNT_SAT
                                                : sum_wide[lps_pkg::COUNT_W-1:0];
        line_next  = (r_line == lps_pkg::COUNT_SAT) ? r_line
                                                    : r_line + lps_pkg::COUNT_W'(1);
        has_next   = r_has_match || i_hit;
        line_mode  = (i_mode == lps_pkg::MODE_FIRST) || (i_mode == lps_pkg::MODE_ALL);
    end

    // Result for the current request, if any.
    always_comb begin
        o_result = '0;
        if (i_step.clear) begin
            if (i_mode == lps_pkg::MODE_COUNT) begin
                o_result.valid = 1'b1;
                o_result.kind  = lps_pkg::KIND_TOTAL;
                o_result.count = r_total;
            end
        end else if (i_step.update && i_step.newline && has_next && line_mode) begin
            o_result.valid       = 1'b1;
            o_result.kind        = lps_pkg::KIND_LINE;
            o_result.line_number = line_next;
        end
    end

    // Per-file counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line      <= '0;
            r_total     <= '0;
            r_line_occ  <= '0;
            r_has_match <= 1'b0;
            r_finished  <= 1'b0;
        end else if (i_step.clear) begin
            r_line      <= '0;
            r_total     <= '0;
            r_line_occ  <= '0;
            r_has_match <= 1'b0;
            r_finished  <= 1'b0;
        end else if (i_step.update) begin
            if (i_step.newline) begin
                r_line      <= line_next;
                r_total     <= total_next;
                r_line_occ  <= '0;
                r_has_match <= 1'b0;
                r_finished  <= has_next && (i_mode == lps_pkg::MODE_FIRST);
            end else begin
                r_line_occ  <= r_line_occ + lps_pkg::COUNT_W'(occ_inc);
                r_has_match <= has_next;
            end
        end
    end

endmodule

@@ hdl/line_pattern_search_top.sv @@
// A request is registered at the input, processed combinationally, and its
// result is loaded into the output register when the input register advances.
// Throughput: one byte per cycle while the output is not stalled, set by the
// window compare and counter update between the input and result registers.
// Reset (synchronous, active low) clears the file state and sets the search
// mode to first-match, the pattern to zero and the pattern length to one.
module line_pattern_search_top #(
    parameter int unsigned PATTERN_MAX = lps_pkg::PATTERN_MAX_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lps_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [lps_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [lps_pkg::BYTE_W-1:0]       i_data_byte,
    input  logic                             i_end_of_file,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_result_kind,
    output logic [lps_pkg::COUNT_W-1:0]      o_line_number,
    output logic [lps_pkg::COUNT_W-1:0]      o_occurrence_count
);

    localparam int unsigned PAT_W = 8 * PATTERN_MAX;

    logic [lps_pkg::MODE_W-1:0]  r_mode;
    logic [PAT_W-1:0]            r_pattern;
    logic [lps_pkg::PLEN_W-1:0]  r_pattern_length;

    logic                        r_s1_valid;
    logic [lps_pkg::BYTE_W-1:0]  r_s1_byte;
    logic                        r_s1_eof;

    logic                        r_out_valid;
    logic                        r_out_kind;
    logic [lps_pkg::COUNT_W-1:0] r_out_line;
    logic [lps_pkg::COUNT_W-1:0] r_out_count;

    logic                        s1_advance;
    logic                        in_accept;
    logic                        finished;
    logic                        hit;
    lps_pkg::t_step              step;
    lps_pkg::t_result            result;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode           <= lps_pkg::MODE_FIRST;
            r_pattern        <= '0;
            r_pattern_length <= lps_pkg::PLEN_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lps_pkg::REG_SEARCH_MODE: begin
                    r_mode <= i_cfg_data[lps_pkg::MODE_W-1:0];
                end
                lps_pkg::REG_PATTERN_BYTES: begin
                    r_pattern <= i_cfg_data[PAT_W-1:0];
                end
                lps_pkg::REG_PATTERN_LENGTH: begin
                    r_pattern_length <= i_cfg_data[lps_pkg::PLEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The registered request moves on whenever the result register is free
    // or being emptied in the same cycle.
    assign s1_advance = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = r_s1_valid && !s1_advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_byte <= i_data_byte;
            r_s1_eof  <= i_end_of_file;
        end
    end

    // Control for the datapath; bytes after a first-mode report are dropped.
    always_comb begin
        step.update  = s1_advance && !r_s1_eof && !finished;
        step.clear   = s1_advance && r_s1_eof;
        step.newline = (r_s1_byte == lps_pkg::CHAR_NEWLINE);
        step.data    = r_s1_byte;
    end

    lps_window #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_window (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (step),
        .i_pattern        (r_pattern),
        .i_pattern_length (r_pattern_length),
        .o_hit            (hit)
    );

    lps_tally u_tally (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_hit      (hit),
        .i_mode     (r_mode),
        .o_finished (finished),
        .o_result   (result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= result.valid;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_out_kind  <= result.kind;
            r_out_line  <= result.line_number;
            r_out_count <= result.count;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_result_kind      = r_out_kind;
    assign o_line_number      = r_out_line;
    assign o_occurrence_count = r_out_count;

endmodule
